### src/mfr_pkg.sv
// Shared types and constants for the meter frame receiver.
// Holds payload structs, parser phases, result codes and register defaults.
// No dependencies.
`timescale 1ns / 1ps

package mfr_pkg;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_CODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_CODE = 2'd3;

	localparam logic [31:0] GAP_TIMEOUT_RST = 32'd50;
	localparam logic [7:0] START_CODE_RST = 8'h68;
	localparam logic [7:0] TYPE_CODE_RST = 8'h41;
	localparam logic [7:0] END_CODE_RST = 8'h16;

	// Length bytes that identify the reply kind.
	localparam logic [7:0] LEN_READ_LONG = 8'h24;
	localparam logic [7:0] LEN_READ_SHORT = 8'h02;
	localparam logic [7:0] LEN_CTRL_LONG = 8'h05;
	localparam logic [7:0] LEN_CTRL_SHORT = 8'h04;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SUM_ERR = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_READ = 2'd1,
		KIND_CTRL = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		PH_HUNT = 4'd0,
		PH_TYPE = 4'd1,
		PH_ADDR0 = 4'd2,
		PH_ADDR1 = 4'd3,
		PH_ADDR2 = 4'd4,
		PH_ADDR3 = 4'd5,
		PH_EXT0 = 4'd6,
		PH_EXT1 = 4'd7,
		PH_FIELD = 4'd8,
		PH_CTRL = 4'd9,
		PH_LEN = 4'd10,
		PH_DATA = 4'd11,
		PH_SUM = 4'd12,
		PH_END = 4'd13
	} phase_t;

	typedef struct packed {
		logic [31:0] gap_timeout;
		logic [7:0] start_code;
		logic [7:0] type_code;
		logic [7:0] end_code;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic [31:0] tick_now;
	} rx_item_t;

	typedef struct packed {
		logic [1:0] frame_status;
		logic [1:0] frame_kind;
		logic [31:0] meter_address;
		logic [15:0] address_extension;
		logic [7:0] field_address;
		logic [7:0] control_code;
		logic [7:0] data_length;
	} res_item_t;

	// A closed frame as the parser hands it to the result stage.
	typedef struct packed {
		logic [7:0] sum;
		logic [7:0] checksum;
		logic [31:0] meter_address;
		logic [15:0] address_extension;
		logic [7:0] field_address;
		logic [7:0] control_code;
		logic [7:0] data_length;
	} frame_rec_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### src/mfr_front.sv
// Byte parser: gap timeout, frame phase tracking, header capture and checksum.
// Pushes one record per frame closed by a valid end code.
// Depends on mfr_pkg.
`timescale 1ns / 1ps

module mfr_front (
	input logic clk,
	input logic arst_n,
	input mfr_pkg::cfg_t cfg,
	input logic accept,
	input mfr_pkg::rx_item_t item,
	output logic push,
	output mfr_pkg::frame_rec_t rec
);

	mfr_pkg::phase_t phase_q, phase_d, cur_phase;
	logic [7:0] left_q, left_d, left_dec;
	logic [31:0] last_q, last_d, gap;
	logic timed_out;
	logic [7:0] sum_q, sum_d, chk_q, chk_d;
	logic [31:0] addr_q, addr_d;
	logic [15:0] ext_q, ext_d;
	logic [7:0] field_q, field_d, ctrl_q, ctrl_d, len_q, len_d;
	logic [7:0] b;

	assign b = item.rx_byte;
	assign gap = item.tick_now - last_q;
	assign timed_out = gap > cfg.gap_timeout;
	assign cur_phase = timed_out ? mfr_pkg::PH_HUNT : phase_q;
	assign left_dec = left_q - 8'd1;

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (cur_phase)
				mfr_pkg::PH_HUNT: phase_d = (b == cfg.start_code) ? mfr_pkg::PH_TYPE
					: mfr_pkg::PH_HUNT;
				mfr_pkg::PH_TYPE: phase_d = (b == cfg.type_code) ? mfr_pkg::PH_ADDR0
					: mfr_pkg::PH_TYPE;
				mfr_pkg::PH_ADDR0: phase_d = mfr_pkg::PH_ADDR1;
				mfr_pkg::PH_ADDR1: phase_d = mfr_pkg::PH_ADDR2;
				mfr_pkg::PH_ADDR2: phase_d = mfr_pkg::PH_ADDR3;
				mfr_pkg::PH_ADDR3: phase_d = mfr_pkg::PH_EXT0;
				mfr_pkg::PH_EXT0: phase_d = mfr_pkg::PH_EXT1;
				mfr_pkg::PH_EXT1: phase_d = mfr_pkg::PH_FIELD;
				mfr_pkg::PH_FIELD: phase_d = mfr_pkg::PH_CTRL;
				mfr_pkg::PH_CTRL: phase_d = mfr_pkg::PH_LEN;
				mfr_pkg::PH_LEN: phase_d = (b != 8'd0) ? mfr_pkg::PH_DATA : mfr_pkg::PH_SUM;
				mfr_pkg::PH_DATA: phase_d = (left_dec == 8'd0) ? mfr_pkg::PH_SUM
					: mfr_pkg::PH_DATA;
				mfr_pkg::PH_SUM: phase_d = mfr_pkg::PH_END;
				mfr_pkg::PH_END: phase_d = mfr_pkg::PH_HUNT;
				default: phase_d = mfr_pkg::PH_HUNT;
			endcase
		end
	end

	always_comb begin
		left_d = left_q;
		last_d = last_q;
		sum_d = sum_q;
		chk_d = chk_q;
		addr_d = addr_q;
		ext_d = ext_q;
		field_d = field_q;
		ctrl_d = ctrl_q;
		len_d = len_q;
		push = 1'b0;
		if (accept) begin
			unique case (cur_phase) inside
				mfr_pkg::PH_HUNT: begin
					if (b == cfg.start_code) begin
						sum_d = b;
						last_d = item.tick_now;
					end
				end
				mfr_pkg::PH_TYPE: begin
					if (b == cfg.type_code) begin
						sum_d = sum_q + b;
						last_d = item.tick_now;
					end
				end
				[mfr_pkg::PH_ADDR0:mfr_pkg::PH_ADDR3]: begin
					// First byte received ends up least significant.
					addr_d = {b, addr_q[31:8]};
					sum_d = sum_q + b;
					last_d = item.tick_now;
				end
				[mfr_pkg::PH_EXT0:mfr_pkg::PH_EXT1]: begin
					ext_d = {b, ext_q[15:8]};
					sum_d = sum_q + b;
					last_d = item.tick_now;
				end
				mfr_pkg::PH_FIELD: begin
					field_d = b;
					sum_d = sum_q + b;
					last_d = item.tick_now;
				end
				mfr_pkg::PH_CTRL: begin
					ctrl_d = b;
					sum_d = sum_q + b;
					last_d = item.tick_now;
				end
				mfr_pkg::PH_LEN: begin
					len_d = b;
					left_d = b;
					sum_d = sum_q + b;
					last_d = item.tick_now;
				end
				mfr_pkg::PH_DATA: begin
					left_d = left_dec;
					sum_d = sum_q + b;
					last_d = item.tick_now;
				end
				mfr_pkg::PH_SUM: begin
					chk_d = b;
					last_d = item.tick_now;
				end
				mfr_pkg::PH_END: begin
					last_d = item.tick_now;
					push = (b == cfg.end_code);
				end
				default: begin
				end
			endcase
		end
	end

	assign rec.sum = sum_q;
	assign rec.checksum = chk_q;
	assign rec.meter_address = addr_q;
	assign rec.address_extension = ext_q;
	assign rec.field_address = field_q;
	assign rec.control_code = ctrl_q;
	assign rec.data_length = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mfr_pkg::PH_HUNT;
			left_q <= '0;
			last_q <= '0;
		end else begin
			phase_q <= phase_d;
			left_q <= left_d;
			last_q <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		sum_q <= sum_d;
		chk_q <= chk_d;
		addr_q <= addr_d;
		ext_q <= ext_d;
		field_q <= field_d;
		ctrl_q <= ctrl_d;
		len_q <= len_d;
	end

endmodule

### src/mfr_queue.sv
// Short register queue of closed frame records between parser and result stage.
// Depends on mfr_pkg.
`timescale 1ns / 1ps

module mfr_queue #(
	parameter int DEPTH = mfr_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input mfr_pkg::q_ctl_t ctl,
	input mfr_pkg::frame_rec_t wr_rec,
	output mfr_pkg::frame_rec_t rd_rec,
	output mfr_pkg::q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	mfr_pkg::frame_rec_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign rd_rec = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q[wr_ptr_q] <= wr_rec;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !stat.full)
		else $error("frame queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> !stat.empty)
		else $error("frame queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("frame queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push && !ctl.pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("frame queue count did not follow a lone write");

endmodule

### src/mfr_back.sv
// Result stage: classifies a closed frame and holds it in the output register.
// Depends on mfr_pkg.
`timescale 1ns / 1ps

module mfr_back (
	input logic clk,
	input logic arst_n,
	input mfr_pkg::frame_rec_t rec,
	input logic rec_avail,
	output logic pop,
	output logic res_valid,
	input logic res_stall,
	output mfr_pkg::res_item_t res_item
);

	logic res_valid_q;
	mfr_pkg::res_item_t res_q, res_d;
	mfr_pkg::status_t status;
	mfr_pkg::kind_t kind;

	always_comb begin
		if (rec.sum != rec.checksum) begin
			status = mfr_pkg::ST_SUM_ERR;
			kind = mfr_pkg::KIND_NONE;
		end else if (rec.data_length == mfr_pkg::LEN_READ_LONG
				|| rec.data_length == mfr_pkg::LEN_READ_SHORT) begin
			status = mfr_pkg::ST_OK;
			kind = mfr_pkg::KIND_READ;
		end else if (rec.data_length == mfr_pkg::LEN_CTRL_LONG
				|| rec.data_length == mfr_pkg::LEN_CTRL_SHORT) begin
			status = mfr_pkg::ST_OK;
			kind = mfr_pkg::KIND_CTRL;
		end else begin
			status = mfr_pkg::ST_UNKNOWN;
			kind = mfr_pkg::KIND_NONE;
		end
		res_d.frame_status = status;
		res_d.frame_kind = kind;
		res_d.meter_address = rec.meter_address;
		res_d.address_extension = rec.address_extension;
		res_d.field_address = rec.field_address;
		res_d.control_code = rec.control_code;
		res_d.data_length = rec.data_length;
	end

	// Load a new result whenever the register is empty or being drained.
	assign pop = rec_avail && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res_item = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

	a_ok_has_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.frame_status == mfr_pkg::ST_OK)
		|-> (res_q.frame_kind != mfr_pkg::KIND_NONE))
		else $error("ok result without a frame kind");

	a_err_no_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.frame_status != mfr_pkg::ST_OK)
		|-> (res_q.frame_kind == mfr_pkg::KIND_NONE))
		else $error("failed result carries a frame kind");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> res_valid_q)
		else $error("loaded result not presented");

endmodule

### src/meter_frame_receiver.sv
// Top level of the meter frame receiver: configuration registers, byte parser,
// frame queue and result stage. Depends on mfr_pkg, mfr_front, mfr_queue, mfr_back.
//
//   channel  direction  handshake              payload
//   rx       in         rx_valid / rx_stall    rx_item (rx_byte, tick_now)
//   res      out        res_valid / res_stall  res_item (status, kind, header)
//   cfg      in         cfg_we                 cfg_index, cfg_data
//
// One byte is taken per cycle while rx_stall is low; the parser settles each byte in
// the cycle it is taken. A frame result passes from its end byte through the queue,
// then the output register. rx_stall is high only while the frame queue is full, which
// takes a held-up result channel and QUEUE_DEPTH closed frames. Reset clears the parser,
// the queue and the output valid, and loads the register defaults.
`timescale 1ns / 1ps

module meter_frame_receiver #(
	parameter int QUEUE_DEPTH = mfr_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic rx_valid,
	output logic rx_stall,
	input mfr_pkg::rx_item_t rx_item,
	output logic res_valid,
	input logic res_stall,
	output mfr_pkg::res_item_t res_item,
	input logic cfg_we,
	input logic [mfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mfr_pkg::CFG_DATA_W-1:0] cfg_data
);

	mfr_pkg::cfg_t cfg_q;
	mfr_pkg::q_ctl_t q_ctl;
	mfr_pkg::q_stat_t q_stat;
	mfr_pkg::frame_rec_t front_rec, queue_rec;
	logic accept;
	logic push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_timeout <= mfr_pkg::GAP_TIMEOUT_RST;
			cfg_q.start_code <= mfr_pkg::START_CODE_RST;
			cfg_q.type_code <= mfr_pkg::TYPE_CODE_RST;
			cfg_q.end_code <= mfr_pkg::END_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfr_pkg::REG_GAP_TIMEOUT: cfg_q.gap_timeout <= cfg_data;
				mfr_pkg::REG_START_CODE: cfg_q.start_code <= cfg_data[7:0];
				mfr_pkg::REG_TYPE_CODE: cfg_q.type_code <= cfg_data[7:0];
				mfr_pkg::REG_END_CODE: cfg_q.end_code <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign rx_stall = q_stat.full;
	assign accept = rx_valid && !rx_stall;
	assign q_ctl.push = push;
	assign q_ctl.pop = pop;

	mfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.accept(accept),
		.item(rx_item),
		.push(push),
		.rec(front_rec)
	);

	mfr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(q_ctl),
		.wr_rec(front_rec),
		.rd_rec(queue_rec),
		.stat(q_stat)
	);

	mfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rec(queue_rec),
		.rec_avail(!q_stat.empty),
		.pop(pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item)
	);

endmodule
